// ===== hdl/mbe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Mandelbrot escape-time counter.
// No dependencies; every other file imports this package.
package mbe_pkg;

    localparam int COORD_W           = 16;
    localparam int COUNT_W           = 8;
    localparam int FRACTION_BITS_DEF = 12;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 8'd30;
    localparam logic [COUNT_W-1:0] LIMIT_CAP      = 8'd254;

    // operand selection for the three shared multipliers
    typedef enum logic [1:0] {
        MUL_PRE_A = 2'd0,
        MUL_PRE_B = 2'd1,
        MUL_QR    = 2'd2,
        MUL_ITER  = 2'd3
    } mul_sel_t;

    // how a request is settled
    typedef enum logic [1:0] {
        FIN_NONE  = 2'd0,
        FIN_ZERO  = 2'd1,
        FIN_INSET = 2'd2,
        FIN_COUNT = 2'd3
    } fin_t;

    typedef struct packed {
        logic     load_point;
        mul_sel_t mul_sel;
        logic     store_pre;
        logic     store_qr;
        logic     init_z;
        logic     upd_z;
        fin_t     finish;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic interior;
        logic stop;
    } status_t;

endpackage

// ===== hdl/mbe_point_if.sv =====
`timescale 1ns / 1ps
// Request channel: one complex point per request.
// Depends on mbe_pkg.
interface mbe_point_if
    import mbe_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_real;
    logic signed [COORD_W-1:0] point_imag;

    modport source (output valid, output point_real, output point_imag, input ready);
    modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

// ===== hdl/mbe_result_if.sv =====
`timescale 1ns / 1ps
// Result channel: escape count and in-set flag.
// Depends on mbe_pkg.
interface mbe_result_if
    import mbe_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] escape_count;
    logic               in_set;

    modport source (output valid, output escape_count, output in_set, input ready);
    modport sink   (input valid, input escape_count, input in_set, output ready);
endinterface

// ===== hdl/mbe_ctrl.sv =====
`timescale 1ns / 1ps
// Controller FSM: sequences pre-checks and iterations, drives the handshakes.
// Depends on mbe_pkg; commands the datapath through cmd_t / status_t.
module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MULA  = 9'b000000010,
        S_MULB  = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_QR    = 9'b000010000,
        S_QRCHK = 9'b000100000,
        S_IMUL  = 9'b001000000,
        S_IUPD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next         = state_reg;
        cmd.load_point     = 1'b0;
        cmd.mul_sel        = MUL_ITER;
        cmd.store_pre      = 1'b0;
        cmd.store_qr       = 1'b0;
        cmd.init_z         = 1'b0;
        cmd.upd_z          = 1'b0;
        cmd.finish         = FIN_NONE;
        cmd.load_out       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_point = 1'b1;
                    state_next     = S_MULA;
                end
            end
            S_MULA:
            begin
                cmd.mul_sel = MUL_PRE_A;
                state_next  = S_MULB;
            end
            S_MULB:
            begin
                cmd.store_pre = 1'b1;
                cmd.mul_sel   = MUL_PRE_B;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                cmd.store_qr = 1'b1;
                if (status.reject)
                begin
                    cmd.finish = FIN_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_QR;
                end
            end
            S_QR:
            begin
                cmd.mul_sel = MUL_QR;
                state_next  = S_QRCHK;
            end
            S_QRCHK:
            begin
                if (status.interior)
                begin
                    cmd.finish = FIN_INSET;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.init_z = 1'b1;
                    state_next = S_IMUL;
                end
            end
            S_IMUL:
            begin
                cmd.mul_sel = MUL_ITER;
                state_next  = S_IUPD;
            end
            S_IUPD:
            begin
                if (status.stop)
                begin
                    cmd.finish = FIN_COUNT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.upd_z  = 1'b1;
                    state_next = S_IMUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/mbe_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: limit register, three shared 18x18 multipliers, pre-check and
// iteration arithmetic, result and output registers. Depends on mbe_pkg.
module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [COUNT_W-1:0]        cfg_write_data,
    input  logic signed [COORD_W-1:0] point_real,
    input  logic signed [COORD_W-1:0] point_imag,
    input  cmd_t                      cmd,
    output status_t                   status,
    output logic [COUNT_W-1:0]        escape_count,
    output logic                      in_set
);

    localparam int OP_W   = 18;
    localparam int PROD_W = 2 * OP_W;
    localparam int FP_ONE_I = 1 << FRACTION_BITS;

    localparam logic signed [OP_W-1:0] FP_TWO     = OP_W'(2 * FP_ONE_I);
    localparam logic signed [OP_W-1:0] FP_FOUR    = OP_W'(4 * FP_ONE_I);
    localparam logic signed [OP_W-1:0] FP_R2_25   = OP_W'((9 * FP_ONE_I) / 4);
    localparam logic signed [OP_W-1:0] FP_R0_1875 = OP_W'((3 * FP_ONE_I) / 16);
    localparam logic signed [OP_W-1:0] FP_R0_0625 = OP_W'(FP_ONE_I / 16);
    localparam logic [COORD_W-1:0]     FP_ONE16     = COORD_W'(FP_ONE_I);
    localparam logic [COORD_W-1:0]     FP_HALF16    = COORD_W'(FP_ONE_I / 2);
    localparam logic [COORD_W-1:0]     FP_QUARTER16 = COORD_W'(FP_ONE_I / 4);
    localparam logic [32:0]            BAIL_WIDE    = 33'(1) << (2 * FRACTION_BITS + 2);

    function automatic logic signed [OP_W-1:0] sext(input logic signed [COORD_W-1:0] v);
        return {{(OP_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] fsq(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRACTION_BITS;
        return s[COORD_W-1:0];
    endfunction

    logic [COUNT_W-1:0]        max_iter_reg;
    logic signed [COORD_W-1:0] cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [COORD_W-1:0] xs_reg, ys_reg, hs_reg;
    logic signed [OP_W-1:0]    q_reg, r_reg;
    logic                      bulb_reg;
    logic [COUNT_W-1:0]        limit_reg, n_reg, res_reg;
    logic [COUNT_W-1:0]        escape_count_reg;
    logic                      in_set_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg;

    logic signed [OP_W-1:0]    a0, b0, a1, b1, a2, b2;
    logic signed [OP_W-1:0]    cr_x, xs_x, ys_x, hs_x;
    logic signed [COORD_W-1:0] cr_half, cr_quarter, cr_one;
    logic signed [PROD_W-1:0]  qr_sh, ys_w, zi_sh;
    logic [32:0]               mag_sum;
    logic [COUNT_W-1:0]        limit_p1;

    assign cr_x       = sext(cr_reg);
    assign xs_x       = sext(xs_reg);
    assign ys_x       = sext(ys_reg);
    assign hs_x       = sext(hs_reg);
    assign cr_half    = cr_reg + FP_HALF16;
    assign cr_quarter = cr_reg - FP_QUARTER16;
    assign cr_one     = cr_reg + FP_ONE16;
    assign limit_p1   = limit_reg + 8'd1;

    always_comb
    begin
        a0 = sext(zr_reg);
        b0 = sext(zr_reg);
        a1 = sext(zi_reg);
        b1 = sext(zi_reg);
        a2 = sext(zr_reg);
        b2 = sext(zi_reg);
        case (cmd.mul_sel)
            MUL_PRE_A:
            begin
                a0 = cr_x;
                b0 = cr_x;
                a1 = sext(ci_reg);
                b1 = sext(ci_reg);
                a2 = sext(cr_half);
                b2 = sext(cr_half);
            end
            MUL_PRE_B:
            begin
                a0 = sext(cr_quarter);
                b0 = sext(cr_quarter);
                a1 = sext(cr_one);
                b1 = sext(cr_one);
            end
            MUL_QR:
            begin
                a0 = q_reg;
                b0 = r_reg;
            end
            MUL_ITER:
            begin
                a0 = sext(zr_reg);
            end
            default:
            begin
                a0 = sext(zr_reg);
            end
        endcase
    end

    // status
    assign status.reject = (cr_x <= -FP_TWO) || (cr_x >= FP_TWO)
                        || (sext(ci_reg) <= -FP_TWO) || (sext(ci_reg) >= FP_TWO)
                        || (xs_x + ys_x >= FP_FOUR)
                        || (hs_x + ys_x > FP_R2_25);

    assign qr_sh = p0_reg >>> (FRACTION_BITS - 2);
    assign ys_w  = {{(PROD_W-COORD_W){ys_reg[COORD_W-1]}}, ys_reg};
    assign status.interior = (qr_sh < ys_w) || bulb_reg;

    assign mag_sum     = {1'b0, p0_reg[31:0]} + {1'b0, p1_reg[31:0]};
    assign status.stop = (n_reg > limit_reg) || (mag_sum >= BAIL_WIDE);

    assign zi_sh = p2_reg >>> (FRACTION_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_write_en)
        begin
            max_iter_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= a0 * b0;
        p1_reg <= a1 * b1;
        p2_reg <= a2 * b2;
        if (cmd.load_point)
        begin
            cr_reg    <= point_real;
            ci_reg    <= point_imag;
            limit_reg <= (max_iter_reg > LIMIT_CAP) ? LIMIT_CAP : max_iter_reg;
        end
        if (cmd.store_pre)
        begin
            xs_reg <= fsq(p0_reg);
            ys_reg <= fsq(p1_reg);
            hs_reg <= fsq(p2_reg);
        end
        if (cmd.store_qr)
        begin
            q_reg    <= sext(fsq(p0_reg)) + ys_x;
            r_reg    <= xs_x + (cr_x >>> 1) + ys_x - FP_R0_1875;
            bulb_reg <= (sext(fsq(p1_reg)) + ys_x) < FP_R0_0625;
        end
        if (cmd.init_z)
        begin
            zr_reg <= cr_reg;
            zi_reg <= ci_reg;
            n_reg  <= '0;
        end
        else if (cmd.upd_z)
        begin
            zr_reg <= fsq(p0_reg) - fsq(p1_reg) + cr_reg;
            zi_reg <= zi_sh[COORD_W-1:0] + ci_reg;
            n_reg  <= n_reg + 8'd1;
        end
        case (cmd.finish)
            FIN_ZERO:  res_reg <= '0;
            FIN_INSET: res_reg <= limit_p1;
            FIN_COUNT: res_reg <= n_reg;
            default:   res_reg <= res_reg;
        endcase
        if (cmd.load_out)
        begin
            escape_count_reg <= res_reg;
            in_set_reg       <= (res_reg == limit_p1);
        end
    end

    assign escape_count = escape_count_reg;
    assign in_set       = in_set_reg;

endmodule

// ===== hdl/mandelbrot_escape_count.sv =====
`timescale 1ns / 1ps
// Mandelbrot escape-time counter, top level: controller, datapath, channels.
// Depends on mbe_pkg, mbe_point_if, mbe_result_if, mbe_ctrl, mbe_datapath.
//
// One request carries a point c in signed 16-bit fixed point (FRACTION_BITS
// fraction bits) and yields one result: the escape count and an in-set flag.
// Points outside the +-2 square, with |c|^2 >= 4 or outside the radius-1.5
// circle around -0.5 get count 0 after the pre-check multiplies;
// points in the main cardioid or the period-2 bulb report max_iter+1 after
// the cardioid multiply; others iterate z = z^2 + c on three shared
// multipliers, one multiply state and one update state per iteration, until
// n exceeds the limit or |z|^2 >= 4. The result is then loaded into the output
// register and the block returns to idle, ready for the next request in the
// same cycle as the result turns valid; a result not yet taken holds the block
// until the output register frees. max_iter (reset 30) is capped at 254; the
// user must write it only while the block is idle (not enforced by the block).
module mandelbrot_escape_count
    import mbe_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    mbe_point_if.sink          point_in,
    mbe_result_if.source       result_out,
    input  logic               cfg_write_en,
    input  logic [COUNT_W-1:0] cfg_write_data
);

    cmd_t    cmd;
    status_t status;

    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point_in.valid),
        .in_ready  (point_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mbe_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .point_real     (point_in.point_real),
        .point_imag     (point_in.point_imag),
        .cmd            (cmd),
        .status         (status),
        .escape_count   (result_out.escape_count),
        .in_set         (result_out.in_set)
    );

    // busy after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point_in.valid && point_in.ready |=> !point_in.ready)
        else $error("request accepted while busy");

    // never overwrite a result still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(result_out.valid && !result_out.ready))
        else $error("pending result overwritten");

    // an in-set result always carries a non-zero count
    a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.in_set |-> result_out.escape_count != '0)
        else $error("in-set result with zero count");

endmodule
